// ===== design/uniform_grid_neighbor_query_top_defines.svh =====
// Assertion macros for the uniform grid neighbour query block.
// Used by the top level; expects a clock named clk and a reset named rst.
`ifndef UNIFORM_GRID_NEIGHBOR_QUERY_TOP_DEFINES_SVH
`define UNIFORM_GRID_NEIGHBOR_QUERY_TOP_DEFINES_SVH

// condition must never hold out of reset
`define UGNQ_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define UGNQ_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define UGNQ_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/ugnq_pkg.sv =====
// Shared types, constants and state codes for the uniform grid neighbour query.
// No dependencies.
`default_nettype none

package ugnq_pkg;

  localparam int GRID_ROWS  = 8;
  localparam int GRID_COLS  = 8;
  localparam int MAX_AGENTS = 64;
  localparam int NCELLS     = GRID_ROWS * GRID_COLS;

  localparam int CELL_W    = (NCELLS > 1) ? $clog2(NCELLS) : 1;
  localparam int COL_W     = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
  localparam int ROW_W     = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
  localparam int DIV_STEPS = ((COL_W > ROW_W) ? COL_W : ROW_W) + 1;
  localparam int AGENT_W   = $clog2(MAX_AGENTS);
  localparam int APTR_W    = $clog2(MAX_AGENTS + 1);

  localparam int ID_W      = 6;
  localparam int COORD_W   = 24;
  localparam int SIZE_W    = 23;
  localparam int RADIUS_W  = 23;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 2;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int DIV_W     = DIFF_W + DIV_STEPS;
  localparam int SPAN_W    = 32;
  localparam int DIST_W    = 2 * DIFF_W + 1;

  localparam logic [APTR_W-1:0] NO_AGENT = APTR_W'(MAX_AGENTS);

  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_HEIGHT = 2'd3;

  typedef enum logic [1:0] {
    MODE_ADD   = 2'd0,
    MODE_MOVE  = 2'd1,
    MODE_QUERY = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t                      mode;
    logic [ID_W-1:0]            agent_id;
    logic signed [COORD_W-1:0]  pos_x;
    logic signed [COORD_W-1:0]  pos_y;
    logic signed [COORD_W-1:0]  old_x;
    logic signed [COORD_W-1:0]  old_y;
    logic [RADIUS_W-1:0]        radius;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0] neighbor_id;
    logic            neighbor_found;
    logic            last;
  } out_item_t;

  typedef struct packed {
    logic [APTR_W-1:0] head;
    logic [APTR_W-1:0] tail;
  } cell_entry_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } pos_entry_t;

  localparam cell_entry_t CELL_EMPTY = '{head: NO_AGENT, tail: NO_AGENT};

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DIV,
    ST_MV_DEC,
    ST_UL_RD,
    ST_UL_HD,
    ST_UL_CHK,
    ST_UL_NXT,
    ST_UL_END,
    ST_AP_RD,
    ST_AP_WR,
    ST_Q_CELL,
    ST_Q_HEAD,
    ST_Q_AG,
    ST_Q_D1,
    ST_Q_D2,
    ST_Q_D3,
    ST_Q_PUSH,
    ST_Q_FIN
  } state_t;

endpackage

`default_nettype wire

// ===== design/uniform_grid_neighbor_query_top.sv =====
// Top level of the uniform grid neighbour query: control sequencer and list memories.
// Depends on ugnq_pkg, ugnq_ram, ugnq_cell_div and the assertion macro header.
`default_nettype none
`include "uniform_grid_neighbor_query_top_defines.svh"

// One item is worked on at a time. Clear resets the cell and agent valid bits at
// once, so no clearing pass follows reset. Add runs the cell locator, then reads
// and writes the cell head/tail RAM. Move, when the cell changes, walks the old
// cell's list to unlink the agent and then links it into the new cell. A query
// steps through every cell, reads the list of each cell whose bounds meet the
// query square, and takes each listed agent in those cells through position and
// link read, difference, squares and compare; results leave through an output
// register and the sequencer waits while it is full and stalled.
module uniform_grid_neighbor_query_top (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [ugnq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [ugnq_pkg::CFG_W-1:0]         cfg_data,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire ugnq_pkg::in_item_t                 in_item,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output ugnq_pkg::out_item_t                     out_item
);

  localparam int AW  = ugnq_pkg::AGENT_W;
  localparam int PW  = ugnq_pkg::APTR_W;
  localparam int CW  = ugnq_pkg::CELL_W;
  localparam int SW  = ugnq_pkg::SPAN_W;
  localparam int DFW = ugnq_pkg::DIFF_W;

  ugnq_pkg::state_t state, state_next;

  logic signed [ugnq_pkg::COORD_W-1:0] origin_x, origin_y;
  logic [ugnq_pkg::SIZE_W-1:0]         cell_width, cell_height, cw_eff, ch_eff;

  ugnq_pkg::in_item_t  item;
  logic [AW-1:0]       a_idx;
  logic [CW-1:0]       oc, nc;
  ugnq_pkg::cell_entry_t ent;
  logic [PW-1:0]       cur, prev, nx, guard, n_found;
  logic [CW-1:0]       q_cell;
  logic [ugnq_pkg::COL_W-1:0] q_col;
  logic signed [SW-1:0] left, bottom, xlo, xhi, ylo, yhi;
  logic [ugnq_pkg::DIST_W-1:0] r2, dist_sum;
  logic [2*ugnq_pkg::RADIUS_W-1:0] r_sq;
  logic signed [DFW-1:0] dx, dy;
  logic [2*DFW-1:0]    sqx, sqy;
  logic                skip;
  logic                pend_valid;
  logic [AW-1:0]       pend_id;
  logic [ugnq_pkg::NCELLS-1:0]     cv;
  logic [ugnq_pkg::MAX_AGENTS-1:0] al;
  logic                cv_q;

  logic accept, id_ok, out_free, cur_none, guard_full, cur_is_a, cell_pass;
  logic found, last_cell, advance;
  ugnq_pkg::cell_entry_t cell_rd;

  logic                  cell_we;
  logic [CW-1:0]         cell_waddr, cell_raddr;
  ugnq_pkg::cell_entry_t cell_wdata, cell_rdata;
  logic                  next_we;
  logic [AW-1:0]         next_waddr;
  logic [PW-1:0]         next_wdata, next_rdata;
  logic                  pos_we;
  ugnq_pkg::pos_entry_t  pos_wdata, pos_rdata;
  logic                  acell_we;
  logic [CW-1:0]         acell_rdata;

  logic div_start, div_new_done, div_old_done;
  logic [CW-1:0] div_new_cell, div_old_cell;

  assign cw_eff = (cell_width == '0) ? ugnq_pkg::SIZE_W'(1) : cell_width;
  assign ch_eff = (cell_height == '0) ? ugnq_pkg::SIZE_W'(1) : cell_height;

  assign in_stall  = state != ugnq_pkg::ST_IDLE;
  assign accept    = in_valid && !in_stall;
  assign id_ok     = {1'b0, in_item.agent_id} < (ugnq_pkg::ID_W + 1)'(ugnq_pkg::MAX_AGENTS);
  assign div_start = accept && id_ok &&
                     (in_item.mode == ugnq_pkg::MODE_ADD || in_item.mode == ugnq_pkg::MODE_MOVE);
  assign out_free  = !out_valid || !out_stall;
  assign cell_rd   = cv_q ? cell_rdata : ugnq_pkg::CELL_EMPTY;
  assign cur_none  = cur >= ugnq_pkg::NO_AGENT;
  assign guard_full = guard >= ugnq_pkg::NO_AGENT;
  assign cur_is_a  = cur == PW'(a_idx);
  assign r_sq      = in_item.radius * in_item.radius;
  assign dist_sum  = ugnq_pkg::DIST_W'(sqx) + ugnq_pkg::DIST_W'(sqy);
  assign found     = !skip && dist_sum < r2 && n_found < PW'(ugnq_pkg::MAX_AGENTS - 1);
  assign last_cell = q_cell == CW'(ugnq_pkg::NCELLS - 1);
  assign cell_pass = !(xhi < left || xlo > left + SW'($signed({1'b0, cw_eff})) ||
                       yhi < bottom || ylo > bottom + SW'($signed({1'b0, ch_eff})));
  assign advance   = (state == ugnq_pkg::ST_Q_CELL && !cell_pass) ||
                     (state == ugnq_pkg::ST_Q_AG && (cur_none || guard_full));

  ugnq_cell_div u_div_new (
    .clk, .rst, .start(div_start),
    .x(in_item.pos_x), .y(in_item.pos_y), .org_x(origin_x), .org_y(origin_y),
    .size_x(cw_eff), .size_y(ch_eff), .done(div_new_done), .cell_idx(div_new_cell)
  );

  ugnq_cell_div u_div_old (
    .clk, .rst, .start(div_start),
    .x(in_item.old_x), .y(in_item.old_y), .org_x(origin_x), .org_y(origin_y),
    .size_x(cw_eff), .size_y(ch_eff), .done(div_old_done), .cell_idx(div_old_cell)
  );

  ugnq_ram #(.WIDTH($bits(ugnq_pkg::cell_entry_t)), .DEPTH(ugnq_pkg::NCELLS)) u_cell_ram (
    .clk, .we(cell_we), .waddr(cell_waddr), .wdata(cell_wdata),
    .raddr(cell_raddr), .rdata(cell_rdata)
  );

  ugnq_ram #(.WIDTH(PW), .DEPTH(ugnq_pkg::MAX_AGENTS)) u_next_ram (
    .clk, .we(next_we), .waddr(next_waddr), .wdata(next_wdata),
    .raddr(cur[AW-1:0]), .rdata(next_rdata)
  );

  ugnq_ram #(.WIDTH($bits(ugnq_pkg::pos_entry_t)), .DEPTH(ugnq_pkg::MAX_AGENTS)) u_pos_ram (
    .clk, .we(pos_we), .waddr(in_item.agent_id[AW-1:0]), .wdata(pos_wdata),
    .raddr(cur[AW-1:0]), .rdata(pos_rdata)
  );

  ugnq_ram #(.WIDTH(CW), .DEPTH(ugnq_pkg::MAX_AGENTS)) u_acell_ram (
    .clk, .we(acell_we), .waddr(a_idx), .wdata(nc),
    .raddr(a_idx), .rdata(acell_rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ugnq_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (in_item.mode)
            ugnq_pkg::MODE_CLEAR: state_next = ugnq_pkg::ST_IDLE;
            ugnq_pkg::MODE_QUERY: state_next = id_ok ? ugnq_pkg::ST_Q_CELL : ugnq_pkg::ST_Q_FIN;
            ugnq_pkg::MODE_ADD,
            ugnq_pkg::MODE_MOVE:  state_next = id_ok ? ugnq_pkg::ST_DIV : ugnq_pkg::ST_IDLE;
          endcase
        end
      end
      ugnq_pkg::ST_DIV: begin
        if (div_new_done && div_old_done) begin
          if (item.mode == ugnq_pkg::MODE_MOVE) begin
            state_next = ugnq_pkg::ST_MV_DEC;
          end else begin
            state_next = al[a_idx] ? ugnq_pkg::ST_IDLE : ugnq_pkg::ST_AP_RD;
          end
        end
      end
      ugnq_pkg::ST_MV_DEC: begin
        priority if (oc == nc) begin
          state_next = ugnq_pkg::ST_IDLE;
        end else if (al[a_idx] && acell_rdata == oc) begin
          state_next = ugnq_pkg::ST_UL_RD;
        end else if (!al[a_idx]) begin
          state_next = ugnq_pkg::ST_AP_RD;
        end else begin
          state_next = ugnq_pkg::ST_IDLE;
        end
      end
      ugnq_pkg::ST_UL_RD:  state_next = ugnq_pkg::ST_UL_HD;
      ugnq_pkg::ST_UL_HD:  state_next = ugnq_pkg::ST_UL_CHK;
      ugnq_pkg::ST_UL_CHK: begin
        state_next = (cur_none || guard_full) ? ugnq_pkg::ST_UL_END : ugnq_pkg::ST_UL_NXT;
      end
      ugnq_pkg::ST_UL_NXT: begin
        state_next = cur_is_a ? ugnq_pkg::ST_UL_END : ugnq_pkg::ST_UL_CHK;
      end
      ugnq_pkg::ST_UL_END: state_next = ugnq_pkg::ST_AP_RD;
      ugnq_pkg::ST_AP_RD:  state_next = ugnq_pkg::ST_AP_WR;
      ugnq_pkg::ST_AP_WR:  state_next = ugnq_pkg::ST_IDLE;
      ugnq_pkg::ST_Q_CELL: begin
        if (cell_pass) begin
          state_next = ugnq_pkg::ST_Q_HEAD;
        end else begin
          state_next = last_cell ? ugnq_pkg::ST_Q_FIN : ugnq_pkg::ST_Q_CELL;
        end
      end
      ugnq_pkg::ST_Q_HEAD: state_next = ugnq_pkg::ST_Q_AG;
      ugnq_pkg::ST_Q_AG: begin
        if (cur_none || guard_full) begin
          state_next = last_cell ? ugnq_pkg::ST_Q_FIN : ugnq_pkg::ST_Q_CELL;
        end else begin
          state_next = ugnq_pkg::ST_Q_D1;
        end
      end
      ugnq_pkg::ST_Q_D1: state_next = ugnq_pkg::ST_Q_D2;
      ugnq_pkg::ST_Q_D2: state_next = ugnq_pkg::ST_Q_D3;
      ugnq_pkg::ST_Q_D3: begin
        state_next = (found && pend_valid) ? ugnq_pkg::ST_Q_PUSH : ugnq_pkg::ST_Q_AG;
      end
      ugnq_pkg::ST_Q_PUSH: state_next = out_free ? ugnq_pkg::ST_Q_AG : ugnq_pkg::ST_Q_PUSH;
      ugnq_pkg::ST_Q_FIN:  state_next = out_free ? ugnq_pkg::ST_IDLE : ugnq_pkg::ST_Q_FIN;
    endcase
  end

  always_comb begin
    cell_we    = 1'b0;
    cell_waddr = nc;
    cell_wdata = ugnq_pkg::CELL_EMPTY;
    next_we    = 1'b0;
    next_waddr = a_idx;
    next_wdata = ugnq_pkg::NO_AGENT;
    acell_we   = 1'b0;
    pos_we     = accept && id_ok && in_item.mode != ugnq_pkg::MODE_CLEAR;
    pos_wdata  = '{x: in_item.pos_x, y: in_item.pos_y};
    priority if (state == ugnq_pkg::ST_Q_CELL) begin
      cell_raddr = q_cell;
    end else if (state == ugnq_pkg::ST_UL_RD) begin
      cell_raddr = oc;
    end else begin
      cell_raddr = nc;
    end
    unique case (state)
      ugnq_pkg::ST_AP_RD: begin
        next_we = 1'b1;
      end
      ugnq_pkg::ST_AP_WR: begin
        cell_we    = 1'b1;
        cell_wdata = '{head: (cell_rd.head >= ugnq_pkg::NO_AGENT) ? PW'(a_idx) : cell_rd.head,
                       tail: PW'(a_idx)};
        next_we    = cell_rd.head < ugnq_pkg::NO_AGENT && cell_rd.tail < ugnq_pkg::NO_AGENT;
        next_waddr = cell_rd.tail[AW-1:0];
        next_wdata = PW'(a_idx);
        acell_we   = 1'b1;
      end
      ugnq_pkg::ST_UL_NXT: begin
        cell_we    = cur_is_a;
        cell_waddr = oc;
        cell_wdata = '{head: (prev >= ugnq_pkg::NO_AGENT) ? next_rdata : ent.head,
                       tail: (ent.tail == cur) ? prev : ent.tail};
        next_we    = cur_is_a && prev < ugnq_pkg::NO_AGENT;
        next_waddr = prev[AW-1:0];
        next_wdata = next_rdata;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ugnq_pkg::ST_IDLE;
      origin_x    <= ugnq_pkg::COORD_W'(-8192);
      origin_y    <= ugnq_pkg::COORD_W'(-8192);
      cell_width  <= ugnq_pkg::SIZE_W'(2048);
      cell_height <= ugnq_pkg::SIZE_W'(2048);
      cv          <= '0;
      al          <= '0;
      out_valid   <= 1'b0;
      pend_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          ugnq_pkg::CFG_ORIGIN_X:    origin_x    <= cfg_data;
          ugnq_pkg::CFG_ORIGIN_Y:    origin_y    <= cfg_data;
          ugnq_pkg::CFG_CELL_WIDTH:  cell_width  <= cfg_data[ugnq_pkg::SIZE_W-1:0];
          ugnq_pkg::CFG_CELL_HEIGHT: cell_height <= cfg_data[ugnq_pkg::SIZE_W-1:0];
        endcase
      end
      if (accept && in_item.mode == ugnq_pkg::MODE_CLEAR) begin
        cv <= '0;
        al <= '0;
      end
      if (state == ugnq_pkg::ST_UL_END) begin
        al[a_idx] <= 1'b0;
      end
      if (state == ugnq_pkg::ST_AP_WR) begin
        al[a_idx] <= 1'b1;
        cv[nc]    <= 1'b1;
      end
      if (accept) begin
        pend_valid <= 1'b0;
      end
      if (state == ugnq_pkg::ST_Q_D3 && found && !pend_valid) begin
        pend_valid <= 1'b1;
      end
      if (state == ugnq_pkg::ST_Q_FIN && out_free) begin
        pend_valid <= 1'b0;
      end
      if ((state == ugnq_pkg::ST_Q_PUSH || state == ugnq_pkg::ST_Q_FIN) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cv_q <= cv[cell_raddr];
    if (accept) begin
      item    <= in_item;
      a_idx   <= in_item.agent_id[AW-1:0];
      r2      <= ugnq_pkg::DIST_W'(r_sq);
      xhi     <= SW'(in_item.pos_x) + SW'($signed({1'b0, in_item.radius}));
      xlo     <= SW'(in_item.pos_x) - SW'($signed({1'b0, in_item.radius}));
      yhi     <= SW'(in_item.pos_y) + SW'($signed({1'b0, in_item.radius}));
      ylo     <= SW'(in_item.pos_y) - SW'($signed({1'b0, in_item.radius}));
      left    <= SW'(origin_x);
      bottom  <= SW'(origin_y);
      q_cell  <= '0;
      q_col   <= '0;
      n_found <= '0;
    end
    if (state == ugnq_pkg::ST_DIV) begin
      nc <= div_new_cell;
      oc <= div_old_cell;
    end
    if (advance) begin
      q_cell <= q_cell + CW'(1);
      if (q_col == ugnq_pkg::COL_W'(ugnq_pkg::GRID_COLS - 1)) begin
        q_col  <= '0;
        left   <= SW'(origin_x);
        bottom <= bottom + SW'($signed({1'b0, ch_eff}));
      end else begin
        q_col <= q_col + ugnq_pkg::COL_W'(1);
        left  <= left + SW'($signed({1'b0, cw_eff}));
      end
    end
    unique case (state)
      ugnq_pkg::ST_UL_HD: begin
        ent   <= cell_rd;
        cur   <= cell_rd.head;
        prev  <= ugnq_pkg::NO_AGENT;
        guard <= '0;
      end
      ugnq_pkg::ST_UL_CHK: begin
        guard <= guard + PW'(1);
      end
      ugnq_pkg::ST_UL_NXT: begin
        prev <= cur;
        cur  <= next_rdata;
      end
      ugnq_pkg::ST_Q_HEAD: begin
        cur   <= cell_rd.head;
        guard <= '0;
      end
      ugnq_pkg::ST_Q_AG: begin
        guard <= guard + PW'(1);
      end
      ugnq_pkg::ST_Q_D1: begin
        dx   <= DFW'(pos_rdata.x) - DFW'(item.pos_x);
        dy   <= DFW'(pos_rdata.y) - DFW'(item.pos_y);
        nx   <= next_rdata;
        skip <= cur_is_a;
      end
      ugnq_pkg::ST_Q_D2: begin
        sqx <= dx * dx;
        sqy <= dy * dy;
      end
      ugnq_pkg::ST_Q_D3: begin
        if (!(found && pend_valid)) begin
          cur <= nx;
        end
        if (found && !pend_valid) begin
          pend_id <= cur[AW-1:0];
          n_found <= n_found + PW'(1);
        end
      end
      ugnq_pkg::ST_Q_PUSH: begin
        if (out_free) begin
          out_item <= '{neighbor_id: ugnq_pkg::ID_W'(pend_id), neighbor_found: 1'b1,
                        last: 1'b0};
          pend_id  <= cur[AW-1:0];
          n_found  <= n_found + PW'(1);
          cur      <= nx;
        end
      end
      ugnq_pkg::ST_Q_FIN: begin
        if (out_free) begin
          out_item <= pend_valid ?
                      '{neighbor_id: ugnq_pkg::ID_W'(pend_id), neighbor_found: 1'b1, last: 1'b1} :
                      '{neighbor_id: '0, neighbor_found: 1'b0, last: 1'b1};
        end
      end
      default: begin
      end
    endcase
  end

  `UGNQ_IMPLY(a_empty_is_last, out_valid && !out_item.neighbor_found, out_item.last, "empty w/o last")
  `UGNQ_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item), "stalled item moved")
  `UGNQ_NEVER(a_found_cap, state != ugnq_pkg::ST_IDLE && n_found > PW'(63), "count over cap")
  `UGNQ_NEXT(a_push_loads, state == ugnq_pkg::ST_Q_PUSH && out_free, out_valid, "push not loaded")

endmodule

`default_nettype wire

// ===== design/ugnq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ugnq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== design/ugnq_cell_div.sv =====
// Cell locator: restoring division of (pos - origin) by cell size, one quotient
// bit per cycle on each axis, clamped to the grid. Depends on ugnq_pkg.
`default_nettype none

module ugnq_cell_div (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 start,
  input  wire logic signed [ugnq_pkg::COORD_W-1:0]  x,
  input  wire logic signed [ugnq_pkg::COORD_W-1:0]  y,
  input  wire logic signed [ugnq_pkg::COORD_W-1:0]  org_x,
  input  wire logic signed [ugnq_pkg::COORD_W-1:0]  org_y,
  input  wire logic        [ugnq_pkg::SIZE_W-1:0]   size_x,
  input  wire logic        [ugnq_pkg::SIZE_W-1:0]   size_y,
  output logic                                      done,
  output logic             [ugnq_pkg::CELL_W-1:0]   cell_idx
);

  localparam int STEPS = ugnq_pkg::DIV_STEPS;
  localparam int DW    = ugnq_pkg::DIV_W;
  localparam int CNT_W = $clog2(STEPS + 1);
  localparam int CPW   = ugnq_pkg::CELL_W + 1;

  logic                                busy;
  logic [CNT_W-1:0]                    cnt;
  logic [DW-1:0]                       rem_x, rem_y, dv_x, dv_y;
  logic [STEPS-1:0]                    q_x, q_y;
  logic signed [ugnq_pkg::DIFF_W-1:0]  diff_x, diff_y;
  logic                                ge_x, ge_y;
  logic [ugnq_pkg::COL_W-1:0]          col;
  logic [ugnq_pkg::ROW_W-1:0]          row;

  assign diff_x = ugnq_pkg::DIFF_W'(x) - ugnq_pkg::DIFF_W'(org_x);
  assign diff_y = ugnq_pkg::DIFF_W'(y) - ugnq_pkg::DIFF_W'(org_y);
  assign ge_x   = rem_x >= dv_x;
  assign ge_y   = rem_y >= dv_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == CNT_W'(1)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt   <= CNT_W'(STEPS);
      rem_x <= diff_x[ugnq_pkg::DIFF_W-1] ? '0 : DW'(diff_x[ugnq_pkg::DIFF_W-2:0]);
      rem_y <= diff_y[ugnq_pkg::DIFF_W-1] ? '0 : DW'(diff_y[ugnq_pkg::DIFF_W-2:0]);
      dv_x  <= DW'(size_x) << (STEPS - 1);
      dv_y  <= DW'(size_y) << (STEPS - 1);
      q_x   <= '0;
      q_y   <= '0;
    end else if (busy) begin
      cnt   <= cnt - CNT_W'(1);
      rem_x <= ge_x ? rem_x - dv_x : rem_x;
      rem_y <= ge_y ? rem_y - dv_y : rem_y;
      dv_x  <= dv_x >> 1;
      dv_y  <= dv_y >> 1;
      q_x   <= {q_x[STEPS-2:0], ge_x};
      q_y   <= {q_y[STEPS-2:0], ge_y};
    end
  end

  always_comb begin
    col = (q_x > STEPS'(ugnq_pkg::GRID_COLS - 1)) ?
          ugnq_pkg::COL_W'(ugnq_pkg::GRID_COLS - 1) : q_x[ugnq_pkg::COL_W-1:0];
    row = (q_y > STEPS'(ugnq_pkg::GRID_ROWS - 1)) ?
          ugnq_pkg::ROW_W'(ugnq_pkg::GRID_ROWS - 1) : q_y[ugnq_pkg::ROW_W-1:0];
    cell_idx = ugnq_pkg::CELL_W'(CPW'(row) * CPW'(ugnq_pkg::GRID_COLS) + CPW'(col));
  end

  assign done = !busy;

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the uniform grid neighbour query block.
// Predicts the cell lists and query answers, drives random items; needs ugnq_pkg.
`timescale 1ns / 1ps

module tb_top;

  logic clk, rst;
  logic cfg_we;
  logic [ugnq_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [ugnq_pkg::CFG_W-1:0] cfg_data;
  logic in_valid, in_stall, out_valid, out_stall;
  ugnq_pkg::in_item_t in_item;
  ugnq_pkg::out_item_t out_item;

  uniform_grid_neighbor_query_top u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  ugnq_pkg::in_item_t pending_items[$];
  ugnq_pkg::out_item_t expected_neighbors[$];
  int send_idle_pct, stall_pct;
  int mismatches, items_sent, results_seen;

  // shadow state of the grid
  longint g_org_x, g_org_y, g_cw, g_ch;
  int head_of[ugnq_pkg::NCELLS], tail_of[ugnq_pkg::NCELLS];
  int next_of[ugnq_pkg::MAX_AGENTS], cell_of_agent[ugnq_pkg::MAX_AGENTS];
  longint px_of[ugnq_pkg::MAX_AGENTS], py_of[ugnq_pkg::MAX_AGENTS];
  // last position queued per agent, used to build well-formed moves
  logic signed [ugnq_pkg::COORD_W-1:0] gen_x[ugnq_pkg::MAX_AGENTS];
  logic signed [ugnq_pkg::COORD_W-1:0] gen_y[ugnq_pkg::MAX_AGENTS];

  function automatic int axis_cell(longint p, longint org, longint sz, int n);
    longint d, i;
    d = p - org;
    i = (d < 0) ? 0 : d / ((sz == 0) ? 1 : sz);
    return (i > n - 1) ? n - 1 : int'(i);
  endfunction

  function automatic int grid_cell(longint x, longint y);
    return axis_cell(y, g_org_y, g_ch, ugnq_pkg::GRID_ROWS) * ugnq_pkg::GRID_COLS
         + axis_cell(x, g_org_x, g_cw, ugnq_pkg::GRID_COLS);
  endfunction

  function automatic void clear_lists();
    for (int i = 0; i < ugnq_pkg::NCELLS; i++) begin
      head_of[i] = ugnq_pkg::MAX_AGENTS;
      tail_of[i] = ugnq_pkg::MAX_AGENTS;
    end
    for (int i = 0; i < ugnq_pkg::MAX_AGENTS; i++) cell_of_agent[i] = ugnq_pkg::NCELLS;
  endfunction

  function automatic void link_agent(int c, int a);
    next_of[a] = ugnq_pkg::MAX_AGENTS;
    if (head_of[c] >= ugnq_pkg::MAX_AGENTS) head_of[c] = a;
    else if (tail_of[c] < ugnq_pkg::MAX_AGENTS) next_of[tail_of[c]] = a;
    tail_of[c] = a;
    cell_of_agent[a] = c;
  endfunction

  function automatic void unlink(int a);
    int c, prev, cur, guard;
    c = cell_of_agent[a];
    prev = ugnq_pkg::MAX_AGENTS;
    guard = 0;
    if (c >= ugnq_pkg::NCELLS) return;
    cur = head_of[c];
    while (cur < ugnq_pkg::MAX_AGENTS && guard++ < ugnq_pkg::MAX_AGENTS) begin
      if (cur == a) begin
        if (prev >= ugnq_pkg::MAX_AGENTS) head_of[c] = next_of[cur];
        else next_of[prev] = next_of[cur];
        if (tail_of[c] == a) tail_of[c] = prev;
        break;
      end
      prev = cur;
      cur = next_of[cur];
    end
    cell_of_agent[a] = ugnq_pkg::NCELLS;
  endfunction

  function automatic void predict_item(ugnq_pkg::in_item_t it);
    int a, n, oc, nc, cur, guard;
    longint px, py, r, cw, ch, left, bottom, dx, dy;
    ugnq_pkg::out_item_t res;
    a = it.agent_id;
    px = it.pos_x;
    py = it.pos_y;
    r = it.radius;
    n = 0;
    if (it.mode == ugnq_pkg::MODE_CLEAR) begin
      clear_lists();
      return;
    end
    px_of[a] = px;
    py_of[a] = py;
    case (it.mode)
      ugnq_pkg::MODE_ADD: begin
        if (cell_of_agent[a] >= ugnq_pkg::NCELLS) link_agent(grid_cell(px, py), a);
      end
      ugnq_pkg::MODE_MOVE: begin
        oc = grid_cell(it.old_x, it.old_y);
        nc = grid_cell(px, py);
        if (oc != nc) begin
          if (cell_of_agent[a] == oc) unlink(a);
          if (cell_of_agent[a] >= ugnq_pkg::NCELLS) link_agent(nc, a);
        end
      end
      default: begin
        cw = (g_cw == 0) ? 1 : g_cw;
        ch = (g_ch == 0) ? 1 : g_ch;
        for (int c = 0; c < ugnq_pkg::NCELLS; c++) begin
          left = g_org_x + (c % ugnq_pkg::GRID_COLS) * cw;
          bottom = g_org_y + (c / ugnq_pkg::GRID_COLS) * ch;
          if (px + r < left || px - r > left + cw) continue;
          if (py + r < bottom || py - r > bottom + ch) continue;
          cur = head_of[c];
          guard = 0;
          while (cur < ugnq_pkg::MAX_AGENTS && guard++ < ugnq_pkg::MAX_AGENTS) begin
            if (cur != a) begin
              dx = px_of[cur] - px;
              dy = py_of[cur] - py;
              if (dx * dx + dy * dy < r * r && n < ugnq_pkg::MAX_AGENTS - 1) begin
                res = '{neighbor_id: ugnq_pkg::ID_W'(cur), neighbor_found: 1'b1, last: 1'b0};
                expected_neighbors.insert(expected_neighbors.size(), res);
                n++;
              end
            end
            cur = next_of[cur];
          end
        end
        if (n == 0) begin
          res = '{neighbor_id: '0, neighbor_found: 1'b0, last: 1'b1};
          expected_neighbors.insert(expected_neighbors.size(), res);
        end else begin
          expected_neighbors[$].last = 1'b1;
        end
      end
    endcase
  endfunction

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_item(in_item);
        items_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_item <= pending_items.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_neighbors.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", out_item);
        end else begin
          if (out_item.neighbor_id !== expected_neighbors[0].neighbor_id ||
              out_item.neighbor_found !== expected_neighbors[0].neighbor_found ||
              out_item.last !== expected_neighbors[0].last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %p, got %p", expected_neighbors[0], out_item);
          end
          void'(expected_neighbors.pop_front());
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic push_item(ugnq_pkg::mode_t m, int a, int px, int py, int ox, int oy, int r);
    ugnq_pkg::in_item_t it;
    it.mode = m;
    it.agent_id = ugnq_pkg::ID_W'(a);
    it.pos_x = ugnq_pkg::COORD_W'(px);
    it.pos_y = ugnq_pkg::COORD_W'(py);
    it.old_x = ugnq_pkg::COORD_W'(ox);
    it.old_y = ugnq_pkg::COORD_W'(oy);
    it.radius = ugnq_pkg::RADIUS_W'(r);
    if (m != ugnq_pkg::MODE_CLEAR) begin
      gen_x[a] = it.pos_x;
      gen_y[a] = it.pos_y;
    end
    pending_items.insert(pending_items.size(), it);
  endtask

  function automatic int rand_coord();
    if ($urandom_range(3) != 0) return $urandom_range(20000) - 10000;
    return int'($signed(24'($urandom)));
  endfunction

  task automatic push_random(int count);
    int a, r, sel;
    for (int k = 0; k < count; k++) begin
      a = $urandom_range(ugnq_pkg::MAX_AGENTS - 1);
      sel = $urandom_range(99);
      r = ($urandom_range(4) == 0) ? int'($urandom_range(23'h7fffff)) : $urandom_range(4096);
      if (sel < 32) push_item(ugnq_pkg::MODE_ADD, a, rand_coord(), rand_coord(), rand_coord(),
                              rand_coord(), r);
      else if (sel < 64) begin
        if ($urandom_range(3) != 0)
          push_item(ugnq_pkg::MODE_MOVE, a, rand_coord(), rand_coord(), gen_x[a], gen_y[a], r);
        else
          push_item(ugnq_pkg::MODE_MOVE, a, rand_coord(), rand_coord(), rand_coord(),
                    rand_coord(), r);
      end else if (sel < 97) push_item(ugnq_pkg::MODE_QUERY, a, rand_coord(), rand_coord(),
                                       rand_coord(), rand_coord(), r);
      else push_item(ugnq_pkg::MODE_CLEAR, a, rand_coord(), rand_coord(), rand_coord(),
                     rand_coord(), r);
    end
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || in_valid || expected_neighbors.size() > 0)
      @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic set_grid(int ox, int oy, int cw, int ch);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= ugnq_pkg::CFG_ORIGIN_X; cfg_data <= ugnq_pkg::CFG_W'(ox);
    @(posedge clk);
    cfg_index <= ugnq_pkg::CFG_ORIGIN_Y; cfg_data <= ugnq_pkg::CFG_W'(oy);
    @(posedge clk);
    cfg_index <= ugnq_pkg::CFG_CELL_WIDTH; cfg_data <= ugnq_pkg::CFG_W'(cw);
    @(posedge clk);
    cfg_index <= ugnq_pkg::CFG_CELL_HEIGHT; cfg_data <= ugnq_pkg::CFG_W'(ch);
    @(posedge clk);
    cfg_we <= 1'b0;
    g_org_x = longint'($signed(24'(ox)));
    g_org_y = longint'($signed(24'(oy)));
    g_cw = cw & 32'h7fffff;
    g_ch = ch & 32'h7fffff;
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    in_valid = 1'b0; in_item = '0; out_stall = 1'b0;
    send_idle_pct = 0; stall_pct = 0;
    mismatches = 0; items_sent = 0; results_seen = 0;
    g_org_x = -8192; g_org_y = -8192; g_cw = 2048; g_ch = 2048;
    clear_lists();
    for (int i = 0; i < ugnq_pkg::MAX_AGENTS; i++) begin
      next_of[i] = ugnq_pkg::MAX_AGENTS;
      px_of[i] = 0; py_of[i] = 0;
      gen_x[i] = '0; gen_y[i] = '0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    push_item(ugnq_pkg::MODE_ADD, 1, 0, 0, 0, 0, 0);
    push_item(ugnq_pkg::MODE_ADD, 2, 256, 256, 0, 0, 0);
    push_item(ugnq_pkg::MODE_ADD, 3, 2100, 0, 0, 0, 0);
    push_item(ugnq_pkg::MODE_ADD, 1, 5000, 5000, 0, 0, 0);
    push_item(ugnq_pkg::MODE_ADD, 4, -8388608, -8388608, 0, 0, 0);
    push_item(ugnq_pkg::MODE_ADD, 5, 8388607, 8388607, 0, 0, 0);
    push_item(ugnq_pkg::MODE_ADD, 9, -6144, 0, 0, 0, 0);
    push_item(ugnq_pkg::MODE_QUERY, 6, 0, 0, 0, 0, 1024);
    push_item(ugnq_pkg::MODE_QUERY, 2, 256, 256, 0, 0, 0);
    push_item(ugnq_pkg::MODE_QUERY, 1, 5000, 5000, 0, 0, 8388607);
    push_item(ugnq_pkg::MODE_MOVE, 2, 3000, 3000, 256, 256, 0);
    push_item(ugnq_pkg::MODE_MOVE, 3, 0, 0, -5000, -5000, 0);
    push_item(ugnq_pkg::MODE_MOVE, 2, 3010, 3010, 3000, 3000, 0);
    push_item(ugnq_pkg::MODE_QUERY, 2, 3010, 3010, 0, 0, 8388607);
    push_item(ugnq_pkg::MODE_CLEAR, 0, 0, 0, 0, 0, 0);
    push_item(ugnq_pkg::MODE_QUERY, 1, 0, 0, 0, 0, 8388607);
    push_item(ugnq_pkg::MODE_ADD, 7, 100, 100, 0, 0, 0);
    push_item(ugnq_pkg::MODE_ADD, 8, 100, 100, 0, 0, 0);
    push_item(ugnq_pkg::MODE_QUERY, 7, 100, 100, 0, 0, 1);
    push_item(ugnq_pkg::MODE_QUERY, 10, 356, 100, 0, 0, 256);
    push_random(30);
    drain();

    set_grid(-8388608, -8388608, 8388607, 8388607);
    send_idle_pct = 84;
    push_random(35);
    drain();

    set_grid(8388607, 8388607, 1, 1);
    send_idle_pct = 0; stall_pct = 84;
    push_random(35);
    drain();

    set_grid(-2048, -1500, 512, 700);
    send_idle_pct = 15; stall_pct = 15;
    push_random(35);
    drain();

    // hold the sender until every answer is back, then resume
    set_grid(-8192, -8192, 2048, 2048);
    send_idle_pct = 0; stall_pct = 0;
    push_random(30);
    drain();
    push_random(30);
    drain();

    $display("Covered %0d items over five grid settings, %0d results checked",
             items_sent, results_seen);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #40000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/ugnq_pkg.sv
design/ugnq_ram.sv
design/ugnq_cell_div.sv
design/uniform_grid_neighbor_query_top.sv
tb/tb_top.sv
